[rtl/crs_pkg.sv]
package crs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 16;

  localparam int PTR_W   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int COORD_W = 24;
  localparam int ACC_W   = 31;
  localparam int PROD_W  = ACC_W + FRAC_BITS + 1;
  localparam int NLAST   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_POS   = 2'd1,
    OP_DERIV = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] POINT_COUNT_RST = CFG_DATA_W'(4);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    logic                 eval;
    logic                 deriv;
    logic                 status;
    logic [FRAC_BITS-1:0] frac;
  } ctl_t;

endpackage

[rtl/catmull_rom_spline_eval.sv]
// Catmull-Rom evaluator: nine register stages (table read, coefficients,
// three multiply/round-add Horner steps, final round and saturate).
// Throughput: one request per cycle while the output is not stalled; the point table
// is kept as four replicas so all four control points are read in the same cycle.
// Reset: pipeline empty, point_count 4, loop_mode 0; table contents undefined.
module catmull_rom_spline_eval (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic [5:0]                        in_point_index,
  input  logic signed [23:0]                in_point_x,
  input  logic signed [23:0]                in_point_y,
  input  logic [5:0]                        in_segment,
  input  logic [15:0]                       in_fraction,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [23:0]                out_result_x,
  output logic signed [23:0]                out_result_y,
  output logic                              out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int W = crs_pkg::CNT_W + 1;

  localparam crs_pkg::prod_t RND_HALF  = crs_pkg::PROD_W'(1) << (crs_pkg::FRAC_BITS - 1);
  localparam crs_pkg::acc_t  ACC_ONE   = crs_pkg::ACC_W'(1);
  localparam crs_pkg::acc_t  COORD_MAX = crs_pkg::ACC_W'((1 << (crs_pkg::COORD_W - 1)) - 1);
  localparam crs_pkg::acc_t  COORD_MIN = -crs_pkg::ACC_W'(1 << (crs_pkg::COORD_W - 1));

  function automatic crs_pkg::acc_t rnd_frac(input crs_pkg::prod_t p);
    crs_pkg::prod_t t;
    t = p + RND_HALF;
    return crs_pkg::ACC_W'(t >>> crs_pkg::FRAC_BITS);
  endfunction

  function automatic crs_pkg::coord_t sat_half(input crs_pkg::acc_t v);
    crs_pkg::acc_t h;
    h = (v + ACC_ONE) >>> 1;
    if (h > COORD_MAX) return crs_pkg::COORD_W'(COORD_MAX);
    if (h < COORD_MIN) return crs_pkg::COORD_W'(COORD_MIN);
    return crs_pkg::COORD_W'(h);
  endfunction

  logic [crs_pkg::CFG_DATA_W-1:0] point_count_r;
  logic                           loop_mode_r;

  logic en, in_acc;

  logic [2*crs_pkg::COORD_W-1:0] pt_mem_r [4][crs_pkg::MAX_POINTS];
  logic [2*crs_pkg::COORD_W-1:0] rd_r [4];
  logic [crs_pkg::PTR_W-1:0]     rd_addr [4];

  logic                 vld_r [crs_pkg::NLAST+1];
  crs_pkg::ctl_t        ctl_r [crs_pkg::NLAST+1];
  crs_pkg::ctl_t        ctl_nxt;

  crs_pkg::acc_t  acc1_r [2], k1_r [2], k2_r [2], k3_r [2];
  crs_pkg::acc_t  k1_d_r [2];
  crs_pkg::acc_t  k2_d_r [2][3];
  crs_pkg::acc_t  k3_d_r [2][5];
  crs_pkg::acc_t  acc3_r [2], acc5_r [2], acc7_r [2];
  crs_pkg::prod_t prod2_r [2], prod4_r [2], prod6_r [2];
  crs_pkg::coord_t res_r [2];

  logic [crs_pkg::CNT_W-1:0] n_sat;
  logic [W-1:0] n_w, seg_w, i0, i2, i3;
  logic         oor, is_eval;

  assign cfg_ready = 1'b1;
  assign en        = !(vld_r[crs_pkg::NLAST] && out_stall);
  assign in_stall  = !en;
  assign in_acc    = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= crs_pkg::POINT_COUNT_RST;
      loop_mode_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        crs_pkg::CFG_POINT_COUNT: point_count_r <= cfg_wdata;
        crs_pkg::CFG_LOOP_MODE:   loop_mode_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // neighbor indices and range check for the incoming request
  always_comb begin
    n_sat = (point_count_r > crs_pkg::CFG_DATA_W'(crs_pkg::MAX_POINTS))
          ? crs_pkg::CNT_W'(crs_pkg::MAX_POINTS) : crs_pkg::CNT_W'(point_count_r);
    n_w   = W'(n_sat);
    seg_w = W'(in_segment);
    if (loop_mode_r) begin
      i0 = (seg_w == '0) ? n_w - W'(1) : seg_w - W'(1);
      i2 = seg_w + W'(1);
      if (i2 >= n_w) i2 = i2 - n_w;
      i3 = seg_w + W'(2);
      if (i3 >= n_w) i3 = i3 - n_w;
      if (i3 >= n_w) i3 = i3 - n_w;
      oor = (n_w == '0) || (seg_w >= n_w);
    end else begin
      i0  = seg_w;
      i2  = seg_w + W'(2);
      i3  = seg_w + W'(3);
      oor = (n_w == '0) || (seg_w + W'(3) >= n_w);
    end
    rd_addr[0] = i0[crs_pkg::PTR_W-1:0];
    rd_addr[1] = (loop_mode_r) ? seg_w[crs_pkg::PTR_W-1:0]
                               : crs_pkg::PTR_W'(seg_w + W'(1));
    rd_addr[2] = i2[crs_pkg::PTR_W-1:0];
    rd_addr[3] = i3[crs_pkg::PTR_W-1:0];

    is_eval        = (in_op == crs_pkg::OP_POS) || (in_op == crs_pkg::OP_DERIV);
    ctl_nxt.eval   = is_eval && !oor;
    ctl_nxt.status = is_eval && oor;
    ctl_nxt.deriv  = (in_op == crs_pkg::OP_DERIV);
    ctl_nxt.frac   = in_fraction[crs_pkg::FRAC_BITS-1:0];
  end

  // write all replicas on a point load; each replica serves one tap
  always_ff @(posedge clk) begin
    if (in_acc && in_op == crs_pkg::OP_WRITE &&
        {1'b0, in_point_index} < 7'(crs_pkg::MAX_POINTS)) begin
      for (int k = 0; k < 4; k++) begin
        pt_mem_r[k][in_point_index[crs_pkg::PTR_W-1:0]] <= {in_point_x, in_point_y};
      end
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        rd_r[k] <= pt_mem_r[k][rd_addr[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= crs_pkg::NLAST; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s <= crs_pkg::NLAST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    crs_pkg::acc_t p0, p1, p2, p3, cb, cc, cd;
    if (en) begin
      ctl_r[0] <= ctl_nxt;
      for (int s = 1; s <= crs_pkg::NLAST; s++) ctl_r[s] <= ctl_r[s-1];

      for (int ax = 0; ax < 2; ax++) begin
        // coefficients; derivative runs the same three steps from zero
        p0 = crs_pkg::ACC_W'($signed(rd_r[0][(1-ax)*crs_pkg::COORD_W +: crs_pkg::COORD_W]));
        p1 = crs_pkg::ACC_W'($signed(rd_r[1][(1-ax)*crs_pkg::COORD_W +: crs_pkg::COORD_W]));
        p2 = crs_pkg::ACC_W'($signed(rd_r[2][(1-ax)*crs_pkg::COORD_W +: crs_pkg::COORD_W]));
        p3 = crs_pkg::ACC_W'($signed(rd_r[3][(1-ax)*crs_pkg::COORD_W +: crs_pkg::COORD_W]));
        cb = p2 - p0;
        cc = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
        cd = p1 + (p1 <<< 1) - p2 - (p2 <<< 1) + p3 - p0;
        if (ctl_r[0].deriv) begin
          acc1_r[ax] <= '0;
          k1_r[ax]   <= cd + (cd <<< 1);
          k2_r[ax]   <= cc <<< 1;
          k3_r[ax]   <= cb;
        end else begin
          acc1_r[ax] <= cd;
          k1_r[ax]   <= cc;
          k2_r[ax]   <= cb;
          k3_r[ax]   <= p1 <<< 1;
        end

        // hold the k-terms alongside their step so each stage uses its own request
        k1_d_r[ax]    <= k1_r[ax];
        k2_d_r[ax][0] <= k2_r[ax];
        for (int j = 1; j < 3; j++) k2_d_r[ax][j] <= k2_d_r[ax][j-1];
        k3_d_r[ax][0] <= k3_r[ax];
        for (int j = 1; j < 5; j++) k3_d_r[ax][j] <= k3_d_r[ax][j-1];

        prod2_r[ax] <= acc1_r[ax] * $signed({1'b0, ctl_r[1].frac});
        acc3_r[ax]  <= k1_d_r[ax] + rnd_frac(prod2_r[ax]);
        prod4_r[ax] <= acc3_r[ax] * $signed({1'b0, ctl_r[3].frac});
        acc5_r[ax]  <= k2_d_r[ax][2] + rnd_frac(prod4_r[ax]);
        prod6_r[ax] <= acc5_r[ax] * $signed({1'b0, ctl_r[5].frac});
        acc7_r[ax]  <= k3_d_r[ax][4] + rnd_frac(prod6_r[ax]);
        res_r[ax]   <= ctl_r[7].eval ? sat_half(acc7_r[ax]) : '0;
      end
    end
  end

  assign out_valid    = vld_r[crs_pkg::NLAST];
  assign out_result_x = res_r[0];
  assign out_result_y = res_r[1];
  assign out_status   = ctl_r[crs_pkg::NLAST].status;

endmodule

[rtl/crs_chk.sv]
module crs_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [23:0]             out_result_x,
  input logic signed [23:0]             out_result_y,
  input logic                           out_status,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_x) &&
      $stable(out_result_y) && $stable(out_status))
    else $error("result changed while stalled");

  // backpressure only comes from a blocked result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // out-of-range results carry zero coordinates
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_result_x == 24'sd0 && out_result_y == 24'sd0)
    else $error("out-of-range result with nonzero coordinates");

  // config port never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind catmull_rom_spline_eval crs_chk u_crs_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_result_x (out_result_x),
  .out_result_y (out_result_y),
  .out_status   (out_status),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
